[rtl/tcs_pkg.sv]
// Shared types, codes and constants for the text console scrollback block.
// No dependencies; every other file of the block but tcs_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tcs_pkg;

    localparam int DEF_MAX_COLS   = 128;
    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_SCROLLBACK = 200;

    localparam int CFG_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [7:0] COLUMNS_RESET = 8'd80;
    localparam logic [6:0] ROWS_RESET    = 7'd25;

    localparam logic [7:0] SPACE_CODE     = 8'd32;
    localparam logic [7:0] NEWLINE_CODE   = 8'd10;
    localparam logic [7:0] BACKSPACE_CODE = 8'd8;

    typedef enum logic [2:0] {
        ACT_PUT   = 3'd0,
        ACT_BACK  = 3'd1,
        ACT_FWD   = 3'd2,
        ACT_CLEAR = 3'd3,
        ACT_READ  = 3'd4
    } t_action;

    typedef enum logic {
        REG_COLUMNS      = 1'b0,
        REG_VISIBLE_ROWS = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] columns;
        logic [6:0] visible_rows;
        logic       wipe;
    } t_cfg;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] char_code;
        logic [5:0] read_row;
        logic [6:0] read_col;
    } t_item;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [6:0] cursor_col;
        logic [7:0] view_back;
        logic [8:0] lines_filled;
        logic       cursor_visible;
    } t_res;

endpackage

`default_nettype wire

[rtl/text_console_scrollback.sv]
// Top level of the text console scrollback block: APB registers, sequencer, result register.
// Depends on tcs_pkg, tcs_regs, tcs_core and tcs_ram.
//
//   channel   direction  handshake                      words
//   in        sink       i_in_valid / o_in_ready        action, char_code, read_row, read_col
//   out       source     o_out_valid / i_out_ready      cell_char, cursor_col, view_back,
//                                                       lines_filled, cursor_visible
//   cfg       APB slave  psel, penable, pwrite, pready  columns (0x0), visible_rows (0x4)
//
// Ordinary characters, scrolls, off-screen reads and unused codes go from S_IDLE straight to S_DONE.
// Reads on screen: S_FIX (at most one ring wrap correction), then S_RD and S_RDW for one RAM read.
// Newline or wrap: S_BLANK blanks the new line, one RAM write per cell of the columns in use.
// Clear, register write and reset: a clearing pass over all (MAX_ROWS + SCROLLBACK) * MAX_COLS
// cells, 33792 at default sizes, one cell per cycle; o_in_ready stays low meanwhile.
// A result waiting on a stalled output holds in the output register while the next word runs.
`timescale 1ns / 1ps
`default_nettype none

module text_console_scrollback #(
    parameter int MAX_COLS   = tcs_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS   = tcs_pkg::DEF_MAX_ROWS,
    parameter int SCROLLBACK = tcs_pkg::DEF_SCROLLBACK
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tcs_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [tcs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [tcs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [2:0]                        i_action,
    input  wire logic [7:0]                        i_char_code,
    input  wire logic [5:0]                        i_read_row,
    input  wire logic [6:0]                        i_read_col,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic      [7:0]                        o_cell_char,
    output logic      [6:0]                        o_cursor_col,
    output logic      [7:0]                        o_view_back,
    output logic      [8:0]                        o_lines_filled,
    output logic                                   o_cursor_visible
);

    import tcs_pkg::*;

    t_cfg  w_cfg;
    t_item w_item;
    t_res  w_res;
    logic  w_res_valid;
    logic  w_res_ready;
    logic  r_out_valid;
    t_res  r_out;

    assign w_item.action    = i_action;
    assign w_item.char_code = i_char_code;
    assign w_item.read_row  = i_read_row;
    assign w_item.read_col  = i_read_col;

    tcs_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    tcs_core #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .SCROLLBACK (SCROLLBACK)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_item      (w_item),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    assign w_res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_cell_char      = r_out.cell_char;
    assign o_cursor_col     = r_out.cursor_col;
    assign o_view_back      = r_out.view_back;
    assign o_lines_filled   = r_out.lines_filled;
    assign o_cursor_visible = r_out.cursor_visible;

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a word is still in progress");

    a_cfg_wipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite) |=> !o_in_ready)
        else $error("register write did not start the clearing pass");

    a_res_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && w_res_ready) |=> o_out_valid)
        else $error("result handed over but output register empty");

    a_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_lines_filled != 9'd0))
        else $error("line count dropped to zero");

endmodule

`default_nettype wire

[rtl/tcs_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]                          i_wdata,
    output logic      [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/tcs_regs.sv]
// APB register file: columns and visible_rows, with a wipe strobe on every write.
// Depends on tcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcs_regs (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [tcs_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [tcs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [tcs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                   pready,
    output tcs_pkg::t_cfg                          o_cfg
);

    import tcs_pkg::*;

    logic [7:0] r_columns;
    logic [6:0] r_rows;
    logic       w_wr;
    t_reg_idx   w_idx;

    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = t_reg_idx'(paddr[2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= COLUMNS_RESET;
            r_rows    <= ROWS_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_COLUMNS:      r_columns <= pwdata[7:0];
                REG_VISIBLE_ROWS: r_rows    <= pwdata[6:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_COLUMNS:      prdata = APB_DATA_W'(r_columns);
            REG_VISIBLE_ROWS: prdata = APB_DATA_W'(r_rows);
        endcase
    end

    assign o_cfg.columns      = r_columns;
    assign o_cfg.visible_rows = r_rows;
    assign o_cfg.wipe         = w_wr;

endmodule

`default_nettype wire

[rtl/tcs_core.sv]
// Console sequencer: cursor, head line, fill count and view offset around the cell RAM.
// Depends on tcs_pkg and tcs_ram.
`timescale 1ns / 1ps
`default_nettype none

module tcs_core #(
    parameter int MAX_COLS   = tcs_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS   = tcs_pkg::DEF_MAX_ROWS,
    parameter int SCROLLBACK = tcs_pkg::DEF_SCROLLBACK
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tcs_pkg::t_cfg  i_cfg,
    input  wire tcs_pkg::t_item i_item,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output logic                o_res_valid,
    input  wire logic           i_res_ready,
    output tcs_pkg::t_res       o_res
);

    import tcs_pkg::*;

    localparam int RING_MAX = MAX_ROWS + SCROLLBACK;
    localparam int DEPTH    = RING_MAX * MAX_COLS;
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int UCW      = $clog2(MAX_COLS + 1);
    localparam int URW      = $clog2(MAX_ROWS + 1);
    localparam int HW       = (RING_MAX > 1) ? $clog2(RING_MAX) : 1;
    localparam int RW       = $clog2(RING_MAX + 1);
    localparam int SW       = RW + 2;
    localparam logic [AW-1:0] LastAddr = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WIPE,
        S_BLANK,
        S_FIX,
        S_RD,
        S_RDW,
        S_DONE
    } t_state;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cursor, n_cursor;
    logic [HW-1:0]   r_head, n_head;
    logic [RW-1:0]   r_filled, n_filled;
    logic [RW-1:0]   r_view, n_view;
    logic [AW-1:0]   r_cnt, n_cnt;
    logic            r_wipe_item, n_wipe_item;
    logic [SW-1:0]   r_s, n_s;
    logic [AW-1:0]   r_addr, n_addr;
    logic [CW-1:0]   r_col, n_col;
    logic [7:0]      r_cell, n_cell;
    logic [UCW-1:0]  r_ucols, n_ucols;
    logic [URW-1:0]  r_urows, n_urows;
    logic [RW-1:0]   r_total;

    logic            ram_we;
    logic [AW-1:0]   ram_addr;
    logic [7:0]      ram_wdata;
    logic [7:0]      ram_rdata;

    logic [8:0]      cols_ext;
    logic [7:0]      rows_ext;
    logic [UCW-1:0]  cur_inc;
    logic            wrap;
    logic [RW-1:0]   lim_cur;
    logic [HW-1:0]   nl_head;
    logic [RW-1:0]   nl_filled;
    logic [RW-1:0]   nl_lim;
    logic [RW-1:0]   nl_view_inc;
    logic [RW-1:0]   nl_view;
    logic [SW-1:0]   s_calc;
    logic            off_screen;
    t_action         act;

    function automatic logic [AW-1:0] row_addr(input logic [HW-1:0] line,
                                               input logic [CW-1:0] col);
        row_addr = AW'(AW'(line) * AW'(MAX_COLS)) + AW'(col);
    endfunction

    tcs_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        cols_ext = {1'b0, i_cfg.columns};
        rows_ext = {1'b0, i_cfg.visible_rows};
        if (cols_ext == 9'd0) begin
            n_ucols = UCW'(1);
        end else if (cols_ext > 9'(MAX_COLS)) begin
            n_ucols = UCW'(MAX_COLS);
        end else begin
            n_ucols = UCW'(cols_ext);
        end
        if (rows_ext == 8'd0) begin
            n_urows = URW'(1);
        end else if (rows_ext > 8'(MAX_ROWS)) begin
            n_urows = URW'(MAX_ROWS);
        end else begin
            n_urows = URW'(rows_ext);
        end
    end

    always_comb begin
        act         = t_action'(i_item.action);
        cur_inc     = UCW'(r_cursor) + UCW'(1);
        wrap        = (cur_inc >= r_ucols);
        lim_cur     = (r_filled > RW'(r_urows)) ? r_filled - RW'(r_urows) : '0;
        nl_head     = ((RW'(r_head) + RW'(1)) == r_total) ? '0 : r_head + HW'(1);
        nl_filled   = (r_filled < r_total) ? r_filled + RW'(1) : r_filled;
        nl_lim      = (nl_filled > RW'(r_urows)) ? nl_filled - RW'(r_urows) : '0;
        nl_view_inc = r_view + RW'(1);
        if (r_view == '0) begin
            nl_view = '0;
        end else if (nl_view_inc > nl_lim) begin
            nl_view = nl_lim;
        end else begin
            nl_view = nl_view_inc;
        end
        s_calc      = SW'(r_head) + SW'(i_item.read_row) + SW'(1)
                      - SW'(r_urows) - SW'(r_view);
        off_screen  = (8'(i_item.read_row) >= 8'(r_urows)) ||
                      (9'(i_item.read_col) >= 9'(r_ucols));
    end

    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_head      = r_head;
        n_filled    = r_filled;
        n_view      = r_view;
        n_cnt       = r_cnt;
        n_wipe_item = r_wipe_item;
        n_s         = r_s;
        n_addr      = r_addr;
        n_col       = r_col;
        n_cell      = r_cell;
        ram_we      = 1'b0;
        ram_addr    = r_addr;
        ram_wdata   = SPACE_CODE;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                ram_addr   = row_addr(r_head, r_cursor);
                if (i_in_valid) begin
                    n_cell  = SPACE_CODE;
                    n_state = S_DONE;
                    unique case (act)
                        ACT_PUT: begin
                            if (i_item.char_code == NEWLINE_CODE) begin
                                n_cursor = '0;
                                n_head   = nl_head;
                                n_filled = nl_filled;
                                n_view   = nl_view;
                                n_cnt    = '0;
                                n_state  = S_BLANK;
                            end else if (i_item.char_code == BACKSPACE_CODE) begin
                                if (r_cursor != '0) begin
                                    n_cursor = r_cursor - CW'(1);
                                    ram_we   = 1'b1;
                                    ram_addr = row_addr(r_head, r_cursor - CW'(1));
                                end
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = i_item.char_code;
                                if (wrap) begin
                                    n_cursor = '0;
                                    n_head   = nl_head;
                                    n_filled = nl_filled;
                                    n_view   = nl_view;
                                    n_cnt    = '0;
                                    n_state  = S_BLANK;
                                end else begin
                                    n_cursor = CW'(cur_inc);
                                end
                            end
                        end
                        ACT_BACK: begin
                            if (r_view < lim_cur) begin
                                n_view = r_view + RW'(1);
                            end
                        end
                        ACT_FWD: begin
                            if (r_view != '0) begin
                                n_view = r_view - RW'(1);
                            end
                        end
                        ACT_CLEAR: begin
                            n_cursor    = '0;
                            n_head      = '0;
                            n_filled    = RW'(1);
                            n_view      = '0;
                            n_cnt       = '0;
                            n_wipe_item = 1'b1;
                            n_state     = S_WIPE;
                        end
                        ACT_READ: begin
                            if (!off_screen) begin
                                n_s     = s_calc;
                                n_col   = CW'(i_item.read_col);
                                n_state = S_FIX;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WIPE: begin
                ram_we   = 1'b1;
                ram_addr = r_cnt;
                n_cnt    = r_cnt + AW'(1);
                if (r_cnt == LastAddr) begin
                    n_state     = r_wipe_item ? S_DONE : S_IDLE;
                    n_wipe_item = 1'b0;
                end
            end
            S_BLANK: begin
                ram_we   = 1'b1;
                ram_addr = row_addr(r_head, CW'(r_cnt));
                n_cnt    = r_cnt + AW'(1);
                if ((UCW'(r_cnt) + UCW'(1)) == r_ucols) begin
                    n_state = S_DONE;
                end
            end
            S_FIX: begin
                if (r_s[SW-1]) begin
                    n_s = r_s + SW'(r_total);
                end else if (r_s >= SW'(r_total)) begin
                    n_s = r_s - SW'(r_total);
                end else begin
                    n_addr  = row_addr(HW'(r_s), r_col);
                    n_state = S_RD;
                end
            end
            S_RD: begin
                ram_addr = r_addr;
                n_state  = S_RDW;
            end
            S_RDW: begin
                n_cell  = ram_rdata;
                n_state = S_DONE;
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg.wipe) begin
            n_cursor    = '0;
            n_head      = '0;
            n_filled    = RW'(1);
            n_view      = '0;
            n_cnt       = '0;
            n_wipe_item = 1'b0;
            n_state     = S_WIPE;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s     <= n_s;
        r_addr  <= n_addr;
        r_col   <= n_col;
        r_cell  <= n_cell;
        r_ucols <= n_ucols;
        r_urows <= n_urows;
        r_total <= RW'(n_urows) + RW'(SCROLLBACK);
        if (!i_rst_n) begin
            r_state     <= S_WIPE;
            r_cursor    <= '0;
            r_head      <= '0;
            r_filled    <= RW'(1);
            r_view      <= '0;
            r_cnt       <= '0;
            r_wipe_item <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_head      <= n_head;
            r_filled    <= n_filled;
            r_view      <= n_view;
            r_cnt       <= n_cnt;
            r_wipe_item <= n_wipe_item;
        end
    end

    assign o_res.cell_char      = r_cell;
    assign o_res.cursor_col     = 7'(r_cursor);
    assign o_res.view_back      = 8'(r_view);
    assign o_res.lines_filled   = 9'(r_filled);
    assign o_res.cursor_visible = (r_view == '0);

endmodule

`default_nettype wire

[tb/text_console_scrollback_tb.sv]
// Self-checking testbench for the text console scrollback block: a directed part, then random
// words over many register settings and handshake pressures, checked against a local predictor.
// Depends on tcs_pkg and the text_console_scrollback RTL.
`timescale 1ns / 1ps

module text_console_scrollback_tb;
    import tcs_pkg::*;

    localparam int NCOL       = DEF_MAX_COLS;
    localparam int NROW       = DEF_MAX_ROWS;
    localparam int NBACK      = DEF_SCROLLBACK;
    localparam int RING_LINES = NROW + NBACK;

    localparam int WATCH_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 300;

    localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
    localparam logic [2:0] ACT_SPARE_MID   = 3'd6;
    localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;

    typedef struct {
        t_item w;
        bit    hold;
    } t_stim;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  o_in_ready;
    t_item                 word_on_bus = '0;
    logic                  o_out_valid;
    logic                  out_ready = 1'b0;
    logic [7:0]            o_cell_char;
    logic [6:0]            o_cursor_col;
    logic [7:0]            o_view_back;
    logic [8:0]            o_lines_filled;
    logic                  o_cursor_visible;

    t_stim pending_words[$];
    t_res  expected_status[$];
    t_res  want_status;
    int    fails = 0;
    int    stall_cycles = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;

    // console state as the predictor sees it
    logic [7:0] cons_cells [RING_LINES*NCOL];
    int         cons_col;
    int         cons_head;
    int         cons_filled;
    int         cons_view;
    logic [7:0] reg_cols;
    logic [6:0] reg_rows;

    text_console_scrollback u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (word_on_bus.action),
        .i_char_code      (word_on_bus.char_code),
        .i_read_row       (word_on_bus.read_row),
        .i_read_col       (word_on_bus.read_col),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_cell_char      (o_cell_char),
        .o_cursor_col     (o_cursor_col),
        .o_view_back      (o_view_back),
        .o_lines_filled   (o_lines_filled),
        .o_cursor_visible (o_cursor_visible)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int cols_in_use();
        if (reg_cols < 1) return 1;
        if (int'(reg_cols) > NCOL) return NCOL;
        return int'(reg_cols);
    endfunction

    function automatic int rows_in_use();
        if (reg_rows < 1) return 1;
        if (int'(reg_rows) > NROW) return NROW;
        return int'(reg_rows);
    endfunction

    function automatic int ring_lines_used();
        return rows_in_use() + NBACK;
    endfunction

    function automatic int scroll_limit();
        int r;
        int lim;
        r = rows_in_use();
        lim = (cons_filled > r) ? cons_filled - r : 0;
        if (lim > ring_lines_used()) lim = ring_lines_used();
        return lim;
    endfunction

    function automatic void blank_line(int line);
        for (int c = 0; c < NCOL; c++) cons_cells[(line % RING_LINES) * NCOL + c] = SPACE_CODE;
    endfunction

    function automatic void wipe_console();
        for (int i = 0; i < RING_LINES * NCOL; i++) cons_cells[i] = SPACE_CODE;
        cons_col = 0;
        cons_head = 0;
        cons_filled = 1;
        cons_view = 0;
    endfunction

    function automatic void advance_line();
        int total;
        total = ring_lines_used();
        cons_col = 0;
        cons_head = (cons_head + 1) % total;
        blank_line(cons_head);
        if (cons_filled < total) cons_filled++;
        if (cons_view > 0) begin
            cons_view++;
            if (cons_view > scroll_limit()) cons_view = scroll_limit();
        end
    endfunction

    function automatic void put_char(logic [7:0] ch);
        int base;
        base = (cons_head % RING_LINES) * NCOL;
        if (ch == NEWLINE_CODE) begin
            advance_line();
        end else if (ch == BACKSPACE_CODE) begin
            if (cons_col > 0) begin
                cons_col--;
                cons_cells[base + (cons_col % NCOL)] = SPACE_CODE;
            end
        end else begin
            cons_cells[base + (cons_col % NCOL)] = ch;
            cons_col++;
            if (cons_col >= cols_in_use()) advance_line();
        end
    endfunction

    function automatic logic [7:0] read_visible(int row, int col);
        int total;
        int rows;
        int view;
        int top;
        int line;
        total = ring_lines_used();
        rows = rows_in_use();
        view = cons_view;
        if (row >= rows || col >= cols_in_use()) return SPACE_CODE;
        if (view > scroll_limit()) view = scroll_limit();
        top = (cons_head % total + 2 * total - (rows - 1) - view) % total;
        line = (top + row) % total;
        return cons_cells[(line % RING_LINES) * NCOL + (col % NCOL)];
    endfunction

    function automatic t_res console_predict(t_item w);
        t_res r;
        logic [7:0] cell_val;
        cell_val = SPACE_CODE;
        case (w.action)
            ACT_PUT: put_char(w.char_code);
            ACT_BACK: if (cons_view < scroll_limit()) cons_view++;
            ACT_FWD: if (cons_view > 0) cons_view--;
            ACT_CLEAR: wipe_console();
            ACT_READ: cell_val = read_visible(int'(w.read_row), int'(w.read_col));
            default: ;
        endcase
        r.cell_char      = cell_val;
        r.cursor_col     = cons_col[6:0];
        r.view_back      = cons_view[7:0];
        r.lines_filled   = cons_filled[8:0];
        r.cursor_visible = (cons_view == 0);
        return r;
    endfunction

    function automatic void push_word(logic [2:0] act, logic [7:0] ch, logic [5:0] row,
                                      logic [6:0] col);
        t_stim s;
        s.w.action    = act;
        s.w.char_code = ch;
        s.w.read_row  = row;
        s.w.read_col  = col;
        s.hold        = 1'b0;
        pending_words.push_back(s);
    endfunction

    function automatic t_item random_word(int put_pct, int back_pct, bit force_read);
        t_item w;
        int pick;
        w.action    = ACT_READ;
        w.char_code = 8'($urandom_range(0, 255));
        w.read_row  = 6'($urandom_range(0, 63));
        w.read_col  = 7'($urandom_range(0, 127));
        pick = force_read ? 1000 : $urandom_range(0, 999);
        if (pick < 3) begin
            w.action = ACT_CLEAR;
        end else if (pick < 23) begin
            w.action = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
        end else if (pick < 23 + put_pct * 10) begin
            w.action = ACT_PUT;
            pick = $urandom_range(0, 99);
            if (pick < 14) w.char_code = NEWLINE_CODE;
            else if (pick < 24) w.char_code = BACKSPACE_CODE;
        end else if (pick < 23 + (put_pct + back_pct) * 10) begin
            w.action = ACT_BACK;
        end else if (pick < 103 + (put_pct + back_pct) * 10) begin
            w.action = ACT_FWD;
        end else begin
            if ($urandom_range(0, 99) < 85) w.read_row = 6'($urandom_range(0, rows_in_use() - 1));
            if ($urandom_range(0, 99) < 85) w.read_col = 7'($urandom_range(0, cols_in_use() - 1));
        end
        return w;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fails++;
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || expected_status.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic cfg_write(t_reg_idx idx, logic [7:0] val);
        logic [APB_DATA_W-1:0] data;
        data = {24'($urandom), val};
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * int'(idx));
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (idx == REG_COLUMNS) reg_cols = data[7:0];
        else reg_rows = data[6:0];
        wipe_console();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(t_reg_idx idx, logic [7:0] val, int n, int put_pct, int back_pct,
                             int snd, int rcv, int hold_at);
        t_stim s;
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        cfg_write(idx, val);
        send_idle_pct  = snd;
        recv_stall_pct = rcv;
        for (int i = 0; i < n; i++) begin
            s.w    = random_word(put_pct, back_pct, i >= n - 3);
            s.hold = (i == hold_at);
            pending_words.push_back(s);
        end
        wait_drained();
    endtask

    // driver: present pending words and predict each accepted one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) expected_status.push_back(console_predict(word_on_bus));
            if (!in_valid || o_in_ready) begin
                if (pending_words.size() == 0
                    || (pending_words[0].hold && expected_status.size() != 0)
                    || $urandom_range(0, 99) < send_idle_pct) begin
                    in_valid <= 1'b0;
                end else begin
                    word_on_bus <= pending_words.pop_front().w;
                    in_valid    <= 1'b1;
                end
            end
        end
    end

    // monitor: compare each accepted status word with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (expected_status.size() == 0) begin
                $display("%0t: unexpected status word, expected none, actual %h", $time,
                         {o_cell_char, o_cursor_col, o_view_back, o_lines_filled,
                          o_cursor_visible});
                fails++;
            end else begin
                want_status = expected_status.pop_front();
                check_field("cell_char", want_status.cell_char, o_cell_char);
                check_field("cursor_col", want_status.cursor_col, o_cursor_col);
                check_field("view_back", want_status.view_back, o_view_back);
                check_field("lines_filled", want_status.lines_filled, o_lines_filled);
                check_field("cursor_visible", want_status.cursor_visible, o_cursor_visible);
            end
        end
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCH_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        reg_cols = COLUMNS_RESET;
        reg_rows = ROWS_RESET;
        wipe_console();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_word(ACT_PUT, 8'h41, 6'd0, 7'd0);
        push_word(ACT_PUT, 8'hFF, 6'd63, 7'd127);
        push_word(ACT_PUT, 8'h00, 6'd0, 7'd0);
        push_word(ACT_READ, 8'h00, 6'd24, 7'd0);
        push_word(ACT_PUT, BACKSPACE_CODE, 6'd0, 7'd0);
        push_word(ACT_READ, 8'h00, 6'd24, 7'd2);
        push_word(ACT_PUT, NEWLINE_CODE, 6'd0, 7'd0);
        push_word(ACT_PUT, BACKSPACE_CODE, 6'd0, 7'd0);
        push_word(ACT_BACK, 8'h00, 6'd0, 7'd0);
        push_word(ACT_FWD, 8'hFF, 6'd63, 7'd127);
        push_word(ACT_SPARE_FIRST, 8'hFF, 6'd63, 7'd127);
        push_word(ACT_SPARE_MID, 8'h55, 6'd21, 7'd42);
        push_word(ACT_SPARE_LAST, 8'hAA, 6'd42, 7'd85);
        push_word(ACT_READ, 8'h00, 6'd63, 7'd0);
        push_word(ACT_READ, 8'h00, 6'd0, 7'd127);
        push_word(ACT_READ, 8'h00, 6'd23, 7'd1);
        push_word(ACT_READ, 8'h00, 6'd0, 7'd0);
        push_word(ACT_CLEAR, 8'h00, 6'd0, 7'd0);
        push_word(ACT_READ, 8'h00, 6'd24, 7'd0);
        push_word(ACT_PUT, 8'h7E, 6'd0, 7'd0);
        push_word(ACT_READ, 8'h00, 6'd24, 7'd0);
        wait_drained();

        run_phase(REG_VISIBLE_ROWS, 8'd1, 100, 55, 12, 0, 0, -1);
        run_phase(REG_COLUMNS, 8'd1, 260, 72, 12, 86, 0, 120);
        run_phase(REG_COLUMNS, 8'd128, 110, 55, 12, 0, 86, -1);
        run_phase(REG_VISIBLE_ROWS, 8'd64, 110, 60, 12, 6, 6, 50);
        run_phase(REG_COLUMNS, 8'd0, 330, 75, 10, 0, 0, -1);
        run_phase(REG_VISIBLE_ROWS, 8'd0, 60, 60, 12, 86, 0, -1);
        run_phase(REG_COLUMNS, 8'd255, 60, 55, 12, 0, 86, -1);
        run_phase(REG_VISIBLE_ROWS, 8'd127, 60, 60, 12, 6, 6, -1);
        run_phase(REG_COLUMNS, 8'd7, 60, 60, 14, 0, 0, -1);
        run_phase(REG_VISIBLE_ROWS, 8'd5, 60, 60, 14, 86, 0, -1);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
